/* rtl/core/ldss_pkg.sv */
// Package for the light-dip seeking steer block.
// Holds the transaction structs, register indexes and order codes.
// No dependencies.
`timescale 1ns / 1ps

package ldss_pkg;

  // Input transaction: one light reading with its tick stamp
  typedef struct packed {
    logic [9:0]  light_sample;
    logic        sample_valid;
    logic [31:0] tick_now;
  } in_item_t;

  // Output transaction: one decision per completed window
  typedef struct packed {
    logic       stop_pulse;
    logic [1:0] drive_order;
    logic [1:0] led_order;
    logic [9:0] average_light;
  } out_item_t;

  // Configuration register indexes
  localparam logic [1:0] REG_SAMPLES_PER_WINDOW = 2'd0;
  localparam logic [1:0] REG_PHASE_PERIOD       = 2'd1;

  localparam logic [9:0]  SAMPLES_RESET   = 10'd500;
  localparam logic [15:0] PERIOD_RESET    = 16'd128;
  localparam logic [10:0] BAND_LOW_RESET  = 11'd1024;
  localparam logic [10:0] BAND_HIGH_RESET = 11'd0;

  // Drive orders
  localparam logic [1:0] DRIVE_KEEP  = 2'd0;
  localparam logic [1:0] DRIVE_RIGHT = 2'd1;
  localparam logic [1:0] DRIVE_LEFT  = 2'd2;

  // LED orders
  localparam logic [1:0] LED_KEEP = 2'd0;
  localparam logic [1:0] LED_RED  = 2'd1;
  localparam logic [1:0] LED_BLUE = 2'd2;

  // ceil(2^18 / 5): floor(y * RECIP5 >> 18) == floor(y / 5) for y < 2^18
  localparam logic [15:0] RECIP5 = 16'd52429;

  localparam int unsigned SUM_W = 20;

endpackage

/* rtl/core/light_dip_seeking_steer.sv */
// Top level of the light-dip seeking steer block.
// Window averaging with a bit-serial divider, band tracking and phase control.
// Depends on ldss_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall / in_item): one light reading per
//   transaction. A reading with sample_valid low is taken and dropped.
//   Output channel (out_valid / out_stall / out_item): one decision per
//   completed window, held in an output register until taken.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//   ready; index 0 is samples_per_window, index 1 is phase_period, other
//   indexes are ignored. Write only while the block is idle.
// Sequence
//   A reading that does not close a window leaves the block idle. A closing
//   reading runs the restoring divider (one quotient bit per cycle over the
//   20-bit sum), then the band and phase arithmetic step, then the emit step,
//   which registers the result. No new reading is taken until the emit step
//   is done, and an output stall holds the emit step.
// Reset
//   rst (synchronous) restores the register defaults, clears the window,
//   phase and direction state and empties the output register.
// Back-pressure
//   A result that waits on out_stall holds the emit step; input stays stalled
//   until the result register can take the new decision.

module light_dip_seeking_steer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ldss_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ldss_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_BAND = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam int unsigned SW = ldss_pkg::SUM_W;
  localparam int unsigned CW = $clog2(SW);
  localparam logic [CW-1:0] DIV_LAST = CW'(SW - 1);

  // Configuration registers
  logic [9:0]  samples_per_window;
  logic [15:0] phase_period;

  // Block state
  logic [1:0]  state;
  logic [31:0] period_start;
  logic        phase_high;
  logic        turn_left;
  logic        last_turn_left;
  logic [10:0] band_low;
  logic [10:0] band_high;
  logic [SW-1:0] window_sum;
  logic [9:0]  window_fill;

  // Work registers for the window in flight
  logic [31:0]   tick;
  logic [9:0]    divisor;
  logic [SW-1:0] quo;
  logic [9:0]    rem;
  logic [CW-1:0] div_count;
  logic [9:0]    avg;
  logic [10:0]   cand_low;
  logic [10:0]   cand_high;
  logic          restart;
  logic [15:0]   elapsed;

  // Accept path
  logic          in_take;
  logic [SW-1:0] sum_next;
  logic [9:0]    fill_next;
  logic [9:0]    len;

  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign sum_next  = window_sum + {{(SW-10){1'b0}}, in_item.light_sample};
  assign fill_next = window_fill + 10'd1;
  assign len       = (samples_per_window == 10'd0) ? 10'd1 : samples_per_window;

  // One restoring divide step: shift in the next dividend bit, try subtract
  logic [10:0] rem_sh;
  logic [11:0] diff;
  logic        qbit;
  logic [9:0]  rem_next;

  assign rem_sh   = {rem, quo[SW-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, divisor};
  assign qbit     = !diff[11];
  assign rem_next = qbit ? diff[9:0] : rem_sh[9:0];

  // Band candidates: round(0.95*avg) and round(1.05*avg), halves up
  logic [14:0] t_low;
  logic [14:0] t_high;
  logic [28:0] p_low;
  logic [28:0] p_high;

  assign t_low  = ({5'd0, avg} << 4) + ({5'd0, avg} << 1) + {5'd0, avg} + 15'd10;
  assign t_high = ({5'd0, avg} << 4) + ({5'd0, avg} << 2) + {5'd0, avg} + 15'd10;
  assign p_low  = {16'd0, t_low[14:2]} * {13'd0, ldss_pkg::RECIP5};
  assign p_high = {16'd0, t_high[14:2]} * {13'd0, ldss_pkg::RECIP5};

  // Sawtooth position from the latched tick
  logic [31:0] elapsed_full;
  assign elapsed_full = tick - period_start;

  // Decision logic for the emit step
  logic        emit_free;
  logic        band_dark;
  logic        band_bright;
  logic        turn_next;
  logic        above_half;
  logic        stop;
  logic [1:0]  drive;
  logic [1:0]  led;
  logic        phase_next;
  logic        last_next;

  assign emit_free   = !out_valid || !out_stall;
  assign band_dark   = {1'b0, avg} < band_low;
  assign band_bright = !band_dark && ({1'b0, avg} > band_high);
  assign turn_next   = band_bright ? !turn_left : turn_left;
  assign stop        = band_bright;
  assign above_half  = {elapsed, 1'b0} > {1'b0, phase_period};

  always_comb begin
    drive      = ldss_pkg::DRIVE_KEEP;
    led        = ldss_pkg::LED_KEEP;
    phase_next = phase_high;
    last_next  = last_turn_left;
    if (!phase_high) begin
      if (above_half) begin
        phase_next = 1'b1;
        led        = ldss_pkg::LED_BLUE;
        if (!turn_next && last_turn_left) begin
          drive     = ldss_pkg::DRIVE_RIGHT;
          last_next = 1'b0;
        end
      end
    end else begin
      if (!above_half) begin
        phase_next = 1'b0;
        led        = ldss_pkg::LED_RED;
        if (turn_next && !last_turn_left) begin
          drive     = ldss_pkg::DRIVE_LEFT;
          last_next = 1'b1;
        end
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_window <= ldss_pkg::SAMPLES_RESET;
      phase_period       <= ldss_pkg::PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ldss_pkg::REG_SAMPLES_PER_WINDOW: samples_per_window <= cfg_data[9:0];
        ldss_pkg::REG_PHASE_PERIOD:       phase_period       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Work registers: payload, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        // Latch the closing window's sum, length and tick
        tick      <= in_item.tick_now;
        divisor   <= len;
        quo       <= sum_next;
        rem       <= 10'd0;
        div_count <= '0;
      end
      ST_DIV: begin
        quo       <= {quo[SW-2:0], qbit};
        rem       <= rem_next;
        div_count <= div_count + CW'(1);
        if (div_count == DIV_LAST) begin
          // Saturate the average at the 10-bit ceiling
          if (|quo[SW-2:9])
            avg <= 10'd1023;
          else
            avg <= {quo[8:0], qbit};
        end
      end
      ST_BAND: begin
        cand_low  <= p_low[28:18];
        cand_high <= p_high[28:18];
        if (elapsed_full >= {16'd0, phase_period}) begin
          restart <= 1'b1;
          elapsed <= 16'd0;
        end else begin
          restart <= 1'b0;
          elapsed <= elapsed_full[15:0];
        end
      end
      default: ;
    endcase
    if (state == ST_EMIT && emit_free) begin
      out_item.stop_pulse    <= stop;
      out_item.drive_order   <= drive;
      out_item.led_order     <= led;
      out_item.average_light <= avg;
    end
  end

  // Control and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      period_start   <= 32'd0;
      phase_high     <= 1'b0;
      turn_left      <= 1'b0;
      last_turn_left <= 1'b0;
      band_low       <= ldss_pkg::BAND_LOW_RESET;
      band_high      <= ldss_pkg::BAND_HIGH_RESET;
      window_sum     <= '0;
      window_fill    <= 10'd0;
    end else begin
      // Raise valid as a decision enters the output register; drop the held
      // result once the receiver takes it
      if (state == ST_EMIT && emit_free)
        out_valid <= 1'b1;
      else if (out_valid && !out_stall)
        out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_take && in_item.sample_valid) begin
            if (fill_next < len) begin
              window_sum  <= sum_next;
              window_fill <= fill_next;
            end else begin
              // Window closes: clear it and start the divider
              window_sum  <= '0;
              window_fill <= 10'd0;
              state       <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_count == DIV_LAST)
            state <= ST_BAND;
        end
        ST_BAND: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          // Hold until the output register is free
          if (emit_free) begin
            if (band_dark || band_bright) begin
              band_low  <= cand_low;
              band_high <= cand_high;
            end
            turn_left      <= turn_next;
            phase_high     <= phase_next;
            last_turn_left <= last_next;
            if (restart)
              period_start <= tick;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
